@@ sv/sao_pkg.sv @@
// Shared constants and transaction payload types for the straight-alpha over blend unit.
// No dependencies.
package sao_pkg;

    localparam int CW = 16;
    localparam int DW = 32;
    localparam int QW = 16;
    localparam int NW = DW + QW;
    localparam int IW = 2;

    localparam logic [CW-1:0] UNIT_ONE  = 16'hFFFF;
    localparam logic [CW-1:0] HALF_UNIT = 16'h7FFF;
    localparam logic [NW-1:0] HALF_SQ   = 48'd2147418112;

    localparam logic [IW-1:0] REG_OPACITY = 2'd0;
    localparam logic [IW-1:0] REG_MASK_EN = 2'd1;

    localparam logic [CW-1:0] OPACITY_RESET = 16'hFFFF;

    // pixel data carried alongside the source alpha stages
    typedef struct packed {
        logic [CW-1:0] br;
        logic [CW-1:0] bg;
        logic [CW-1:0] bb;
        logic [CW-1:0] ba;
        logic [CW-1:0] lr;
        logic [CW-1:0] lg;
        logic [CW-1:0] lb;
        logic          last;
    } pix_t;

    // data carried alongside the color divider
    typedef struct packed {
        logic [CW-1:0] br;
        logic [CW-1:0] bg;
        logic [CW-1:0] bb;
        logic [CW-1:0] ba;
        logic          zero;
        logic [DW-1:0] d;
        logic          last;
    } mix_t;

endpackage

@@ sv/straight_alpha_over_blend_unit.sv @@
// Straight-alpha Porter-Duff over compositor, top level.
// Depends on sao_pkg, sao_front, sao_div, sao_prep.
//
// Usage:
//   Pixel channel: drive the backdrop, layer, mask and last_in fields and pulse
//   start. A pixel is taken at every edge with start high and busy low; busy is
//   always low, so one pixel per clock is accepted with no gaps.
//   Result channel: done is high for one cycle with out_red/green/blue,
//   out_alpha_value and last_out; results come in pixel order, one per pixel.
//   Pipeline: 5 source alpha stages, 4 term stages, 16 color divider stages and
//   1 output stage lie between the accepting edge and the done cycle.
//   Throughput is one pixel per clock.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
//   opacity, index 1 is mask_enable (cfg_data bit 0), other indexes are dropped.
//   cfg_ready is always high. Write only while no pixel is in flight.
//   Reset: clears all valid bits; opacity returns to 1.0, mask disabled.
//   The receiver cannot stall; every result is presented exactly once.
module straight_alpha_over_blend_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [15:0]               back_red,
    input  logic [15:0]               back_green,
    input  logic [15:0]               back_blue,
    input  logic [15:0]               back_alpha,
    input  logic [15:0]               layer_red,
    input  logic [15:0]               layer_green,
    input  logic [15:0]               layer_blue,
    input  logic [15:0]               layer_alpha,
    input  logic [15:0]               mask_value,
    input  logic                      last_in,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [sao_pkg::IW-1:0]    cfg_index,
    input  logic [15:0]               cfg_data,
    output logic                      done,
    output logic [15:0]               out_red,
    output logic [15:0]               out_green,
    output logic [15:0]               out_blue,
    output logic [15:0]               out_alpha_value,
    output logic                      last_out
);
    import sao_pkg::*;

    logic [CW-1:0]          opacity_reg;
    logic                   mask_en_reg;

    pix_t                   in_pix;
    logic                   fr_valid;
    logic [CW-1:0]          fr_alpha;
    pix_t                   fr_pix;

    logic                   pr_valid;
    logic [2:0][NW-1:0]     pr_num;
    logic [DW-1:0]          pr_den;
    mix_t                   pr_mix;

    logic                   c_valid;
    logic [2:0][QW-1:0]     c_quot;
    logic [$bits(mix_t)-1:0] c_side;
    mix_t                   c_mix;

    logic                   done_reg;
    logic [CW-1:0]          red_next, red_reg, green_next, green_reg;
    logic [CW-1:0]          blue_next, blue_reg, oa_next, oa_reg;
    logic                   last_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opacity_reg <= OPACITY_RESET;
            mask_en_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_OPACITY: opacity_reg <= cfg_data;
                REG_MASK_EN: mask_en_reg <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        in_pix.br   = back_red;
        in_pix.bg   = back_green;
        in_pix.bb   = back_blue;
        in_pix.ba   = back_alpha;
        in_pix.lr   = layer_red;
        in_pix.lg   = layer_green;
        in_pix.lb   = layer_blue;
        in_pix.last = last_in;
    end

    // rounded alpha = (product + S*S/2) / (S*S)
    sao_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start & ~busy),
        .in_pix      (in_pix),
        .layer_alpha (layer_alpha),
        .mask_value  (mask_value),
        .opacity     (opacity_reg),
        .mask_enable (mask_en_reg),
        .out_valid   (fr_valid),
        .out_alpha   (fr_alpha),
        .out_pix     (fr_pix)
    );

    sao_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_alpha  (fr_alpha),
        .in_pix    (fr_pix),
        .out_valid (pr_valid),
        .out_num   (pr_num),
        .out_den   (pr_den),
        .out_mix   (pr_mix)
    );

    sao_div #(
        .DW    (DW),
        .QW    (QW),
        .LANES (3),
        .SW    ($bits(mix_t))
    ) u_color_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pr_valid),
        .in_num    (pr_num),
        .in_den    (pr_den),
        .in_side   (pr_mix),
        .out_valid (c_valid),
        .out_quot  (c_quot),
        .out_side  (c_side)
    );

    assign c_mix = mix_t'(c_side);

    // out alpha = (D + S/2) / S: x = q0*S + r with r = q0 + x[15:0] <= 2S
    always_comb
    begin
        logic [DW-1:0] x;
        logic [CW:0]   r;
        logic [CW:0]   q;
        x = c_mix.d + DW'(HALF_UNIT);
        r = {1'b0, x[DW-1:CW]} + {1'b0, x[CW-1:0]};
        q = {1'b0, x[DW-1:CW]};
        if (r >= {1'b0, UNIT_ONE})
        begin
            q = q + 1'b1;
        end
        if (r >= {UNIT_ONE, 1'b0})
        begin
            q = q + 1'b1;
        end
        if (c_mix.zero)
        begin
            red_next   = c_mix.br;
            green_next = c_mix.bg;
            blue_next  = c_mix.bb;
            oa_next    = c_mix.ba;
        end
        else
        begin
            red_next   = c_quot[2];
            green_next = c_quot[1];
            blue_next  = c_quot[0];
            oa_next    = q[CW] ? UNIT_ONE : q[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= c_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        oa_reg    <= oa_next;
        last_reg  <= c_mix.last;
    end

    assign done            = done_reg;
    assign out_red         = red_reg;
    assign out_green       = green_reg;
    assign out_blue        = blue_reg;
    assign out_alpha_value = oa_reg;
    assign last_out        = last_reg;

endmodule

@@ sv/sao_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage, LANES numerators
// sharing one divisor, with a sideband word carried in step. No dependencies.
module sao_div #(
    parameter int DW    = 32,
    parameter int QW    = 16,
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [LANES-1:0][DW+QW-1:0]      in_num,
    input  logic [DW-1:0]                    in_den,
    input  logic [SW-1:0]                    in_side,
    output logic                             out_valid,
    output logic [LANES-1:0][QW-1:0]         out_quot,
    output logic [SW-1:0]                    out_side
);

    logic                       vld  [QW+1];
    logic [LANES-1:0][DW-1:0]   rem  [QW+1];
    logic [LANES-1:0][QW-1:0]   low  [QW+1];
    logic [LANES-1:0][QW-1:0]   quo  [QW+1];
    logic [DW-1:0]              den  [QW+1];
    logic [SW-1:0]              side [QW+1];

    // numerator must satisfy num < den * 2^QW so the upper part starts below den
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            rem[0][l] = in_num[l][DW+QW-1:QW];
            low[0][l] = in_num[l][QW-1:0];
            quo[0][l] = '0;
        end
    end
    assign vld[0]  = in_valid;
    assign den[0]  = in_den;
    assign side[0] = in_side;

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [LANES-1:0][DW-1:0] rem_next, rem_reg;
        logic [LANES-1:0][QW-1:0] low_next, low_reg;
        logic [LANES-1:0][QW-1:0] quo_next, quo_reg;
        logic                     vld_reg;
        logic [DW-1:0]            den_reg;
        logic [SW-1:0]            side_reg;

        always_comb
        begin
            logic [DW:0] trial;
            logic        ge;
            for (int l = 0; l < LANES; l++)
            begin
                trial = {rem[k][l], low[k][l][QW-1]};
                ge    = (trial >= {1'b0, den[k]});
                if (ge)
                begin
                    trial = trial - {1'b0, den[k]};
                end
                rem_next[l] = trial[DW-1:0];
                low_next[l] = {low[k][l][QW-2:0], 1'b0};
                quo_next[l] = {quo[k][l][QW-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else
            begin
                vld_reg <= vld[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg  <= rem_next;
            low_reg  <= low_next;
            quo_reg  <= quo_next;
            den_reg  <= den[k];
            side_reg <= side[k];
        end

        assign vld[k+1]  = vld_reg;
        assign rem[k+1]  = rem_reg;
        assign low[k+1]  = low_reg;
        assign quo[k+1]  = quo_reg;
        assign den[k+1]  = den_reg;
        assign side[k+1] = side_reg;
    end

    assign out_valid = vld[QW];
    assign out_quot  = quo[QW];
    assign out_side  = side[QW];

endmodule

@@ sv/sao_front.sv @@
// Source alpha stages: layer alpha times mask (1.0 if disabled) times opacity, rounded and divided by S*S.
// Depends on sao_pkg.
module sao_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  sao_pkg::pix_t         in_pix,
    input  logic [15:0]           layer_alpha,
    input  logic [15:0]           mask_value,
    input  logic [15:0]           opacity,
    input  logic                  mask_enable,
    output logic                  out_valid,
    output logic [15:0]           out_alpha,
    output sao_pkg::pix_t         out_pix
);
    import sao_pkg::*;

    logic          vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg;
    logic [DW-1:0] p1_next, p1_reg;
    logic [NW-1:0] p2_next, p2_reg;
    logic [DW-1:0] hi_next, hi_reg, y_next, y_reg;
    logic [DW-1:0] q1_next, q1_reg;
    logic [CW-1:0] alpha_next, alpha_reg;
    pix_t          pix1_reg, pix2_reg, pix3_reg, pix4_reg, pix5_reg;

    // divide by S twice: x = hi*S + (hi + lo) since 2^16 = S + 1
    always_comb
    begin
        logic [CW-1:0] m;
        logic [CW:0]   r1;
        logic [CW:0]   r2;
        logic [CW:0]   q;
        logic [DW-1:0] c;
        m       = mask_enable ? mask_value : UNIT_ONE;
        p1_next = DW'(layer_alpha) * DW'(m);
        p2_next = NW'(p1_reg) * NW'(opacity) + HALF_SQ;

        // the rounded product stays small enough that hi + lo fits 32 bits
        hi_next = p2_reg[NW-1:CW];
        y_next  = p2_reg[NW-1:CW] + DW'(p2_reg[CW-1:0]);

        r1      = {1'b0, y_reg[DW-1:CW]} + {1'b0, y_reg[CW-1:0]};
        c       = DW'(r1 >= {1'b0, UNIT_ONE}) + DW'(r1 >= {UNIT_ONE, 1'b0});
        q1_next = hi_reg + DW'(y_reg[DW-1:CW]) + c;

        r2         = {1'b0, q1_reg[DW-1:CW]} + {1'b0, q1_reg[CW-1:0]};
        q          = {1'b0, q1_reg[DW-1:CW]}
                   + {{CW{1'b0}}, (r2 >= {1'b0, UNIT_ONE})}
                   + {{CW{1'b0}}, (r2 >= {UNIT_ONE, 1'b0})};
        alpha_next = q[CW] ? UNIT_ONE : q[CW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        hi_reg    <= hi_next;
        y_reg     <= y_next;
        q1_reg    <= q1_next;
        alpha_reg <= alpha_next;
        pix1_reg  <= in_pix;
        pix2_reg  <= pix1_reg;
        pix3_reg  <= pix2_reg;
        pix4_reg  <= pix3_reg;
        pix5_reg  <= pix4_reg;
    end

    assign out_valid = vld5_reg;
    assign out_alpha = alpha_reg;
    assign out_pix   = pix5_reg;

endmodule

@@ sv/sao_prep.sv @@
// Blend term stages: a_term, blended alpha denominator and per-channel numerators.
// Depends on sao_pkg.
module sao_prep (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [15:0]           in_alpha,
    input  sao_pkg::pix_t         in_pix,
    output logic                  out_valid,
    output logic [2:0][47:0]      out_num,
    output logic [31:0]           out_den,
    output sao_pkg::mix_t         out_mix
);
    import sao_pkg::*;

    // stage C
    logic          vc_reg;
    logic [DW-1:0] t_next, t_c_reg;
    logic [CW-1:0] alpha_c_reg;
    logic          zero_c_reg;
    pix_t          pix_c_reg;
    // stage D
    logic                   vd_reg;
    logic [DW-1:0]          d_next, d_d_reg, t_d_reg;
    logic [2:0][DW-1:0]     lc_next, lc_reg;
    logic                   zero_d_reg;
    pix_t                   pix_d_reg;
    // stage E
    logic                   ve_reg;
    logic [2:0][NW-1:0]     n1_next, n1_reg, bt_next, bt_reg;
    logic [DW-1:0]          d_e_reg;
    logic                   zero_e_reg;
    pix_t                   pix_e_reg;
    // stage F
    logic                   vf_reg;
    logic [2:0][NW-1:0]     num_next, num_reg;
    mix_t                   mix_next, mix_reg;

    always_comb
    begin
        logic [2:0][CW-1:0] layer_c;
        logic [2:0][CW-1:0] back_c;
        t_next  = DW'(in_pix.ba) * DW'(UNIT_ONE - in_alpha);
        d_next  = ({alpha_c_reg, 16'h0000} - {16'h0000, alpha_c_reg}) + t_c_reg;
        layer_c = {pix_c_reg.lr, pix_c_reg.lg, pix_c_reg.lb};
        back_c  = {pix_e_reg.br, pix_e_reg.bg, pix_e_reg.bb};
        for (int i = 0; i < 3; i++)
        begin
            lc_next[i]  = DW'(layer_c[i]) * DW'(alpha_c_reg);
            n1_next[i]  = {lc_reg[i], 16'h0000} - NW'(lc_reg[i]);
            bt_next[i]  = NW'(pix_d_reg.br) * NW'(t_d_reg);
        end
        bt_next[1] = NW'(pix_d_reg.bg) * NW'(t_d_reg);
        bt_next[0] = NW'(pix_d_reg.bb) * NW'(t_d_reg);
        for (int i = 0; i < 3; i++)
        begin
            num_next[i] = n1_reg[i] + bt_reg[i] + NW'(d_e_reg[DW-1:1]);
        end
        mix_next.br   = back_c[2];
        mix_next.bg   = back_c[1];
        mix_next.bb   = back_c[0];
        mix_next.ba   = pix_e_reg.ba;
        mix_next.zero = zero_e_reg;
        mix_next.d    = d_e_reg;
        mix_next.last = pix_e_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else
        begin
            vc_reg <= in_valid;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t_c_reg     <= t_next;
        alpha_c_reg <= in_alpha;
        zero_c_reg  <= (in_alpha == '0);
        pix_c_reg   <= in_pix;

        d_d_reg     <= d_next;
        t_d_reg     <= t_c_reg;
        lc_reg      <= lc_next;
        zero_d_reg  <= zero_c_reg;
        pix_d_reg   <= pix_c_reg;

        n1_reg      <= n1_next;
        bt_reg      <= bt_next;
        d_e_reg     <= d_d_reg;
        zero_e_reg  <= zero_d_reg;
        pix_e_reg   <= pix_d_reg;

        num_reg     <= num_next;
        mix_reg     <= mix_next;
    end

    assign out_valid = vf_reg;
    assign out_num   = num_reg;
    assign out_den   = mix_reg.d;
    assign out_mix   = mix_reg;

endmodule
